@@ rtl/che_pkg.sv @@
package che_pkg;

   // Field widths and fixed-point formats.
   localparam int SAMPLE_BITS = 24;
   localparam int COEF_W      = 32;
   localparam int COEF_FRAC   = 20;
   localparam int ACC_W       = 40;
   localparam int NUM_COEF    = 11;
   localparam int LIMIT_W     = 16;

   // Shared multiplier operand widths: A carries the accumulator or the DC state,
   // B carries the sample or the pole constant.
   localparam int MUL_A_W = ACC_W;
   localparam int MUL_B_W = (SAMPLE_BITS > 25) ? SAMPLE_BITS : 25;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   localparam int HORNER_SHIFT = SAMPLE_BITS - 1;
   localparam int POLE_SHIFT   = 23;
   localparam int OUT_SHIFT    = SAMPLE_BITS - 1 - COEF_FRAC;

   // Pole 0.999 in Q0.23.
   localparam logic signed [MUL_B_W-1:0] POLE_Q23 = MUL_B_W'(8380219);

   // Register map, indexed by the 64-bit word address.
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_IDX_W  = 3;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_PAIR0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_PAIR1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_PAIR2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_PAIR3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_PAIR4 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_TOP   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_WARMUP     = 3'd6;

   localparam logic [CSR_DATA_W-1:0] COEF_PAIR0_RESET = 64'h0010_0000_0000_0000;
   localparam logic [LIMIT_W-1:0]    WARMUP_RESET     = 16'd10000;

endpackage

@@ rtl/chebyshev_harmonic_exciter_core.sv @@
// Channel  Direction  Handshake               Word
// req      in         req_valid / req_stall   req_sample_in
// rsp      out        rsp_valid / rsp_stall   rsp_sample_out, rsp_clipped
// csr      in/out     APB write/read          64-bit registers at 8*index
//
// After acceptance a sample passes through one pole multiply and ten Horner steps,
// each a multiply state and an accumulate state on the single shared 40x25
// multiplier, then one DC blocker state and one output state; the next sample is
// accepted in the idle state that follows the registered result.
// Reset is synchronous and returns the coefficients and warm-up limit to defaults.
// A result held by rsp_stall delays the output state and so the next acceptance.
module chebyshev_harmonic_exciter_core
   import che_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                          rsp_clipped,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [CSR_DATA_W-1:0]         csr_pwdata,
   output logic [CSR_DATA_W-1:0]         csr_prdata,
   output logic                          csr_pready
);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_PMUL = 7'b0000010,
      S_PACC = 7'b0000100,
      S_HMUL = 7'b0001000,
      S_HACC = 7'b0010000,
      S_FIN  = 7'b0100000,
      S_OUT  = 7'b1000000
   } state_type;

   localparam int K_W     = 4;
   localparam int HSUM_W  = PROD_W - HORNER_SHIFT + 1;
   localparam int DSUM_W  = ACC_W + 3;
   localparam int OSUM_W  = ACC_W + OUT_SHIFT;
   localparam int PTERM_W = ACC_W + 1;
   localparam logic [K_W-1:0] K_TOP = K_W'(NUM_COEF - 2);

   localparam logic signed [HSUM_W-1:0] HSUM_MAX = signed'(HSUM_W'({1'b0, {(COEF_W-1){1'b1}}}));
   localparam logic signed [HSUM_W-1:0] HSUM_MIN = -HSUM_MAX - HSUM_W'(1);
   localparam logic signed [DSUM_W-1:0] DSUM_MAX = signed'(DSUM_W'({1'b0, {(ACC_W-1){1'b1}}}));
   localparam logic signed [DSUM_W-1:0] DSUM_MIN = -DSUM_MAX - DSUM_W'(1);
   localparam logic signed [OSUM_W-1:0] OSUM_MAX =
      signed'(OSUM_W'({1'b0, {(SAMPLE_BITS-1){1'b1}}}));
   localparam logic signed [OSUM_W-1:0] OSUM_MIN = -OSUM_MAX - OSUM_W'(1);

   state_type                    state_ff, state_in;
   logic [K_W-1:0]               k_ff, k_in;
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic signed [COEF_W-1:0]     y_ff, y_in;
   logic signed [PROD_W-1:0]     prod_ff, prod_in;
   logic signed [ACC_W:0]        pterm_ff, pterm_in;
   logic signed [ACC_W-1:0]      last_poly_ff, last_poly_in;
   logic signed [ACC_W-1:0]      dc_out_ff, dc_out_in;
   logic [LIMIT_W-1:0]           warm_cnt_ff, warm_cnt_in;
   logic                         warm_ff, warm_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;
   logic                         rsp_clip_ff, rsp_clip_in;

   logic [CSR_DATA_W-1:0] coef_pair0_ff, coef_pair0_in;
   logic [CSR_DATA_W-1:0] coef_pair1_ff, coef_pair1_in;
   logic [CSR_DATA_W-1:0] coef_pair2_ff, coef_pair2_in;
   logic [CSR_DATA_W-1:0] coef_pair3_ff, coef_pair3_in;
   logic [CSR_DATA_W-1:0] coef_pair4_ff, coef_pair4_in;
   logic [COEF_W-1:0]     coef_top_ff, coef_top_in;
   logic [LIMIT_W-1:0]    warmup_limit_ff, warmup_limit_in;

   logic                         csr_wr;
   logic [CSR_IDX_W-1:0]         csr_idx;
   logic [CSR_DATA_W-1:0]        pair_sel;
   logic signed [COEF_W-1:0]     coef_sel;
   logic signed [MUL_A_W-1:0]    mul_a;
   logic signed [MUL_B_W-1:0]    mul_b;
   logic signed [PROD_W-1:0]     prod_rnd_h, prod_rnd_p;
   logic signed [HSUM_W-1:0]     hsum;
   logic signed [COEF_W-1:0]     hsat;
   logic signed [DSUM_W-1:0]     dsum;
   logic signed [ACC_W-1:0]      dsat;
   logic signed [OSUM_W-1:0]     oval;
   logic                         out_free;

   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:CSR_ADDR_W-CSR_IDX_W];
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_idx)
         REG_COEF_PAIR0: csr_prdata = coef_pair0_ff;
         REG_COEF_PAIR1: csr_prdata = coef_pair1_ff;
         REG_COEF_PAIR2: csr_prdata = coef_pair2_ff;
         REG_COEF_PAIR3: csr_prdata = coef_pair3_ff;
         REG_COEF_PAIR4: csr_prdata = coef_pair4_ff;
         REG_COEF_TOP:   csr_prdata = CSR_DATA_W'(coef_top_ff);
         REG_WARMUP:     csr_prdata = CSR_DATA_W'(warmup_limit_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // Coefficient k lives in pair k/2, low half for even k.
   always_comb begin
      case (k_ff[K_W-1:1])
         3'd0:    pair_sel = coef_pair0_ff;
         3'd1:    pair_sel = coef_pair1_ff;
         3'd2:    pair_sel = coef_pair2_ff;
         3'd3:    pair_sel = coef_pair3_ff;
         3'd4:    pair_sel = coef_pair4_ff;
         default: pair_sel = '0;
      endcase
      coef_sel = k_ff[0] ? signed'(pair_sel[CSR_DATA_W-1:COEF_W])
                         : signed'(pair_sel[COEF_W-1:0]);
   end

   // The shared multiplier: pole times DC state, or accumulator times sample.
   always_comb begin
      if (state_ff == S_PMUL) begin
         mul_a = dc_out_ff;
         mul_b = POLE_Q23;
      end else begin
         mul_a = MUL_A_W'(y_ff);
         mul_b = MUL_B_W'(x_ff);
      end
      prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   // Round half up, then the accumulate and saturate paths.
   always_comb begin
      prod_rnd_h = prod_ff + (PROD_W'(1) <<< (HORNER_SHIFT - 1));
      prod_rnd_p = prod_ff + (PROD_W'(1) <<< (POLE_SHIFT - 1));
      hsum = HSUM_W'(prod_rnd_h >>> HORNER_SHIFT) + HSUM_W'(coef_sel);
      if (hsum > HSUM_MAX)
         hsat = {1'b0, {(COEF_W-1){1'b1}}};
      else if (hsum < HSUM_MIN)
         hsat = {1'b1, {(COEF_W-1){1'b0}}};
      else
         hsat = hsum[COEF_W-1:0];

      dsum = DSUM_W'(y_ff) + DSUM_W'(pterm_ff) - DSUM_W'(last_poly_ff);
      if (dsum > DSUM_MAX)
         dsat = {1'b0, {(ACC_W-1){1'b1}}};
      else if (dsum < DSUM_MIN)
         dsat = {1'b1, {(ACC_W-1){1'b0}}};
      else
         dsat = dsum[ACC_W-1:0];

      oval = OSUM_W'(dc_out_ff) <<< OUT_SHIFT;
   end

   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in        = state_ff;
      k_in            = k_ff;
      x_in            = x_ff;
      y_in            = y_ff;
      pterm_in        = pterm_ff;
      last_poly_in    = last_poly_ff;
      dc_out_in       = dc_out_ff;
      warm_cnt_in     = warm_cnt_ff;
      warm_in         = warm_ff;
      rsp_valid_in    = rsp_valid_ff & rsp_stall;
      rsp_sample_in   = rsp_sample_ff;
      rsp_clip_in     = rsp_clip_ff;
      coef_pair0_in   = coef_pair0_ff;
      coef_pair1_in   = coef_pair1_ff;
      coef_pair2_in   = coef_pair2_ff;
      coef_pair3_in   = coef_pair3_ff;
      coef_pair4_in   = coef_pair4_ff;
      coef_top_in     = coef_top_ff;
      warmup_limit_in = warmup_limit_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               x_in     = req_sample_in;
               y_in     = signed'(coef_top_ff);
               k_in     = K_TOP;
               state_in = S_PMUL;
            end
         end
         S_PMUL: state_in = S_PACC;
         S_PACC: begin
            pterm_in = PTERM_W'(prod_rnd_p >>> POLE_SHIFT);
            state_in = S_HMUL;
         end
         S_HMUL: state_in = S_HACC;
         S_HACC: begin
            y_in = hsat;
            if (k_ff == '0) begin
               state_in = S_FIN;
            end else begin
               k_in     = k_ff - K_W'(1);
               state_in = S_HMUL;
            end
         end
         S_FIN: begin
            dc_out_in    = dsat;
            last_poly_in = ACC_W'(y_ff);
            warm_in      = warm_cnt_ff < warmup_limit_ff;
            if (warm_cnt_ff < warmup_limit_ff)
               warm_cnt_in = warm_cnt_ff + LIMIT_W'(1);
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (warm_ff) begin
                  rsp_sample_in = '0;
                  rsp_clip_in   = 1'b0;
               end else if (oval > OSUM_MAX) begin
                  rsp_sample_in = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
                  rsp_clip_in   = 1'b1;
               end else if (oval < OSUM_MIN) begin
                  rsp_sample_in = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
                  rsp_clip_in   = 1'b1;
               end else begin
                  rsp_sample_in = oval[SAMPLE_BITS-1:0];
                  rsp_clip_in   = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // Any coefficient write restarts the filter history and the warm-up.
      if (csr_wr) begin
         unique case (csr_idx)
            REG_COEF_PAIR0: coef_pair0_in = csr_pwdata;
            REG_COEF_PAIR1: coef_pair1_in = csr_pwdata;
            REG_COEF_PAIR2: coef_pair2_in = csr_pwdata;
            REG_COEF_PAIR3: coef_pair3_in = csr_pwdata;
            REG_COEF_PAIR4: coef_pair4_in = csr_pwdata;
            REG_COEF_TOP:   coef_top_in   = csr_pwdata[COEF_W-1:0];
            REG_WARMUP:     warmup_limit_in = csr_pwdata[LIMIT_W-1:0];
            default: ;
         endcase
         if (csr_idx <= REG_COEF_TOP) begin
            last_poly_in = '0;
            dc_out_in    = '0;
            warm_cnt_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         last_poly_ff    <= '0;
         dc_out_ff       <= '0;
         warm_cnt_ff     <= '0;
         coef_pair0_ff   <= COEF_PAIR0_RESET;
         coef_pair1_ff   <= '0;
         coef_pair2_ff   <= '0;
         coef_pair3_ff   <= '0;
         coef_pair4_ff   <= '0;
         coef_top_ff     <= '0;
         warmup_limit_ff <= WARMUP_RESET;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         last_poly_ff    <= last_poly_in;
         dc_out_ff       <= dc_out_in;
         warm_cnt_ff     <= warm_cnt_in;
         coef_pair0_ff   <= coef_pair0_in;
         coef_pair1_ff   <= coef_pair1_in;
         coef_pair2_ff   <= coef_pair2_in;
         coef_pair3_ff   <= coef_pair3_in;
         coef_pair4_ff   <= coef_pair4_in;
         coef_top_ff     <= coef_top_in;
         warmup_limit_ff <= warmup_limit_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      pterm_ff      <= pterm_in;
      warm_ff       <= warm_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_clip_ff   <= rsp_clip_in;
      if (state_ff == S_PMUL || state_ff == S_HMUL) begin
         prod_ff <= prod_in;
      end
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_clipped    = rsp_clip_ff;

endmodule

@@ rtl/che_checker.sv @@
module che_checker
   import che_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [SAMPLE_BITS-1:0] rsp_sample_out,
   input logic                   rsp_clipped
);

   localparam logic [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample_out) && $stable(rsp_clipped))
      else $error("stalled result word changed");

   // The block works on one word at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted while a word is in flight");

   // A clipped result sits at a rail.
   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |-> rsp_sample_out == OUT_MAX || rsp_sample_out == OUT_MIN)
      else $error("clipped result not at full scale");

   // No result can appear right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind chebyshev_harmonic_exciter_core che_checker u_che_checker (.*);

@@ tb/chebyshev_harmonic_exciter_checker.sv @@
`timescale 1ns / 100ps

module chebyshev_harmonic_exciter_checker
   import che_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   input  logic                          rsp_clipped,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [CSR_DATA_W-1:0]         csr_pwdata,
   input  logic [CSR_DATA_W-1:0]         csr_prdata,
   input  logic                          csr_pready,
   output int                            fail_count,
   output int                            words_in_flight
);

   // DC blocker pole, 0.999 in Q0.23.
   localparam longint DC_POLE        = 8380219;
   localparam int     POLE_FRAC      = 23;
   localparam int     DEFAULT_WARMUP = 10000;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic                          clipped;
   } shaped_word_type;

   shaped_word_type          shaped_q[$];
   logic signed [COEF_W-1:0] coef[NUM_COEF];
   logic [LIMIT_W-1:0]       warmup_limit;
   logic [LIMIT_W-1:0]       warmup_count;
   logic signed [ACC_W-1:0]  prev_poly;
   logic signed [ACC_W-1:0]  dc_state;
   int                       mismatches = 0;

   assign fail_count = mismatches;

   // Add half an LSB, then shift right arithmetically: rounds ties toward +inf.
   function automatic longint round_half_up(input longint v, input int shift);
      return (v + (longint'(1) <<< (shift - 1))) >>> shift;
   endfunction

   function automatic longint clamp(input longint v, input int bits, output logic hit);
      longint hi;
      longint lo;
      hi  = (longint'(1) <<< (bits - 1)) - 1;
      lo  = -hi - 1;
      hit = 1'b0;
      if (v > hi) begin
         hit = 1'b1;
         return hi;
      end
      if (v < lo) begin
         hit = 1'b1;
         return lo;
      end
      return v;
   endfunction

   function automatic void clear_history();
      prev_poly    = '0;
      dc_state     = '0;
      warmup_count = '0;
   endfunction

   function automatic shaped_word_type shape_sample(input logic signed [SAMPLE_BITS-1:0] x_in);
      shaped_word_type w;
      longint          x;
      longint          y;
      longint          dc;
      longint          o;
      logic            hit;
      logic            clip;
      x = x_in;
      y = coef[NUM_COEF-1];
      for (int k = NUM_COEF - 2; k >= 0; k--) begin
         y = clamp(round_half_up(x * y, SAMPLE_BITS - 1) + coef[k], COEF_W, hit);
      end
      dc = y + round_half_up(longint'(dc_state) * DC_POLE, POLE_FRAC) - longint'(prev_poly);
      dc = clamp(dc, ACC_W, hit);
      prev_poly = y[ACC_W-1:0];
      dc_state  = dc[ACC_W-1:0];
      // The state keeps running during warm-up; only the output word is zeroed.
      if (warmup_count < warmup_limit) begin
         warmup_count = warmup_count + 1'b1;
         w.sample_out = '0;
         w.clipped    = 1'b0;
      end else begin
         o = clamp(dc <<< (SAMPLE_BITS - 1 - COEF_FRAC), SAMPLE_BITS, clip);
         w.sample_out = o[SAMPLE_BITS-1:0];
         w.clipped    = clip;
      end
      return w;
   endfunction

   function automatic void check_field(input string field, input logic signed [63:0] want,
                                       input logic signed [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : watch
      shaped_word_type      due;
      logic [CSR_IDX_W-1:0] idx;
      if (reset) begin
         foreach (coef[k]) coef[k] = '0;
         coef[1]      = COEF_W'(1) << COEF_FRAC;
         warmup_limit = LIMIT_W'(DEFAULT_WARMUP);
         clear_history();
         shaped_q.delete();
      end else begin
         idx = csr_paddr[CSR_ADDR_W-1:CSR_ADDR_W-CSR_IDX_W];
         if (rsp_valid && !rsp_stall) begin
            if (shaped_q.size() == 0) begin
               $error("unexpected word: sample_out %0d, clipped %0b",
                      rsp_sample_out, rsp_clipped);
               mismatches++;
            end else begin
               due = shaped_q.pop_front();
               check_field("sample_out", due.sample_out, rsp_sample_out);
               check_field("clipped", due.clipped, rsp_clipped);
            end
         end
         if (req_valid && !req_stall) begin
            shaped_q.push_back(shape_sample(req_sample_in));
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (idx)
               REG_COEF_PAIR0, REG_COEF_PAIR1, REG_COEF_PAIR2, REG_COEF_PAIR3,
               REG_COEF_PAIR4: begin
                  coef[2 * idx]     = csr_pwdata[COEF_W-1:0];
                  coef[2 * idx + 1] = csr_pwdata[2*COEF_W-1:COEF_W];
                  clear_history();
               end
               REG_COEF_TOP: begin
                  coef[NUM_COEF-1] = csr_pwdata[COEF_W-1:0];
                  clear_history();
               end
               REG_WARMUP: warmup_limit = csr_pwdata[LIMIT_W-1:0];
               default: ;
            endcase
         end
         if (csr_psel && csr_penable && !csr_pwrite && csr_pready) begin
            case (idx)
               REG_COEF_PAIR0, REG_COEF_PAIR1, REG_COEF_PAIR2, REG_COEF_PAIR3,
               REG_COEF_PAIR4: begin
                  check_field("coef_pair", {coef[2 * idx + 1], coef[2 * idx]}, csr_prdata);
               end
               REG_COEF_TOP: begin
                  check_field("coef_top", coef[NUM_COEF-1], signed'(csr_prdata[COEF_W-1:0]));
               end
               REG_WARMUP: check_field("warmup_limit", warmup_limit, csr_prdata[LIMIT_W-1:0]);
               default: ;
            endcase
         end
      end
      words_in_flight <= shaped_q.size();
   end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench
   import che_pkg::*;
();

   localparam int GAP_PCT        = 30;
   localparam int GAP_MAX        = 40;
   localparam int STALL_PCT      = 21;
   localparam int DRAIN_CYCLES   = 30;
   localparam int QUIET_LIMIT    = 2000;
   localparam int RANDOM_SAMPLES = 1530;
   localparam int OFS_W          = CSR_ADDR_W - CSR_IDX_W;

   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = 3'd7;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic [COEF_W-1:0]             COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic [COEF_W-1:0]             COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};

   typedef enum {SWING_FULL, SWING_QUIET, SWING_HELD, SWING_EDGES} swing_type;

   logic                          clock         = 1'b0;
   logic                          reset         = 1'b1;
   logic                          req_valid     = 1'b0;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_sample_in = '0;
   logic                          rsp_valid;
   logic                          rsp_stall     = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_out;
   logic                          rsp_clipped;
   logic                          csr_psel      = 1'b0;
   logic                          csr_penable   = 1'b0;
   logic                          csr_pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0]         csr_paddr     = '0;
   logic [CSR_DATA_W-1:0]         csr_pwdata    = '0;
   logic [CSR_DATA_W-1:0]         csr_prdata;
   logic                          csr_pready;

   int fail_count;
   int words_in_flight;
   int quiet_cycles = 0;
   int random_sent  = 0;
   bit steady       = 1'b0;

   chebyshev_harmonic_exciter_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .rsp_clipped    (rsp_clipped),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   chebyshev_harmonic_exciter_checker u_exciter_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample_in   (req_sample_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample_out  (rsp_sample_out),
      .rsp_clipped     (rsp_clipped),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .fail_count      (fail_count),
      .words_in_flight (words_in_flight)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && !steady && ($urandom_range(99) < STALL_PCT);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // A transfer leaves psel high so that the next one can follow without a gap.
   task automatic csr_access(input logic write, input logic [CSR_IDX_W-1:0] idx,
                             input logic [CSR_DATA_W-1:0] data,
                             input logic [OFS_W-1:0] offset);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {idx, offset};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic csr_release();
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic read_back_all();
      for (int i = 0; i <= REG_WARMUP; i++) begin
         csr_access(1'b0, CSR_IDX_W'(i), {$urandom, $urandom}, '0);
      end
   endtask

   // Upper bits of the data bus carry noise that the register must drop.
   task automatic write_warmup(input logic [LIMIT_W-1:0] limit);
      csr_access(1'b1, REG_WARMUP, {$urandom, 16'($urandom), limit}, '0);
   endtask

   task automatic write_all_coefs(input logic [COEF_W-1:0] value);
      for (int i = 0; i <= REG_COEF_PAIR4; i++) begin
         csr_access(1'b1, CSR_IDX_W'(i), {value, value}, '0);
      end
      csr_access(1'b1, REG_COEF_TOP, {$urandom, value}, '0);
   endtask

   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value);
      if (!steady && $urandom_range(99) < GAP_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(GAP_MAX, 1)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= value;
      do @(posedge clock); while (req_stall);
   endtask

   // Registers change only once every word owed by the block has come out.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (words_in_flight != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [COEF_W-1:0] pick_coef(input logic wild);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 30) return '0;
      if (!wild) begin
         if (roll < 80) return COEF_W'(int'($urandom_range(1 << 20)) - (1 << 19));
         return COEF_W'(int'($urandom_range(1 << 15)) - (1 << 14));
      end
      if (roll < 60) return COEF_W'(int'($urandom_range(1 << 20)) - (1 << 19));
      if (roll < 80) return $urandom;
      return $urandom_range(1) ? COEF_MAX : COEF_MIN;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(
      input swing_type swing, input logic signed [SAMPLE_BITS-1:0] held);
      case (swing)
         SWING_QUIET: return SAMPLE_BITS'(int'($urandom_range(1 << 19)) - (1 << 18));
         SWING_HELD:  return ($urandom_range(9) == 0) ? SAMPLE_BITS'($urandom) : held;
         SWING_EDGES: begin
            return $urandom_range(1) ? SAMPLE_MAX - SAMPLE_BITS'($urandom_range(1))
                                     : SAMPLE_MIN + SAMPLE_BITS'($urandom_range(1));
         end
         default:     return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   task automatic load_setting();
      logic        wild;
      int unsigned roll;
      wild = ($urandom_range(99) < 30);
      if ($urandom_range(99) < 80) begin
         for (int i = 0; i <= REG_COEF_PAIR4; i++) begin
            if ($urandom_range(1)) begin
               csr_access(1'b1, CSR_IDX_W'(i), {pick_coef(wild), pick_coef(wild)}, '0);
            end
         end
         if ($urandom_range(1)) begin
            csr_access(1'b1, REG_COEF_TOP, {$urandom, pick_coef(wild)}, '0);
         end
      end
      // A warm-up limit alone leaves the filter history and the count as they were.
      roll = $urandom_range(99);
      if (roll < 25) write_warmup('0);
      else if (roll < 85) write_warmup(LIMIT_W'($urandom_range(8, 1)));
      else if (roll < 95) write_warmup(LIMIT_W'($urandom_range(40, 9)));
      if ($urandom_range(99) < 15) begin
         csr_access(1'b1, REG_UNMAPPED, {$urandom, $urandom}, OFS_W'($urandom));
      end
      if ($urandom_range(99) < 10) read_back_all();
      csr_release();
   endtask

   initial begin
      swing_type                     swing;
      logic signed [SAMPLE_BITS-1:0] held;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset values, then the default unity polynomial with a short warm-up.
      read_back_all();
      write_warmup(16'd2);
      csr_release();
      send_sample('0);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(24'sd1);
      send_sample(-24'sd1);
      send_sample(24'sh400000);
      settle();

      // Largest positive coefficients everywhere, no warm-up.
      write_all_coefs(COEF_MAX);
      write_warmup('0);
      csr_release();
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample('0);
      settle();

      write_all_coefs(COEF_MIN);
      csr_release();
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(-24'sd1);
      settle();

      // Longest warm-up, then a smaller limit that the running count already passed.
      read_back_all();
      csr_access(1'b1, REG_UNMAPPED, {$urandom, $urandom}, OFS_W'($urandom));
      write_warmup('1);
      read_back_all();
      csr_release();
      repeat (4) send_sample(SAMPLE_BITS'($urandom));
      settle();
      write_warmup(16'd2);
      csr_release();
      repeat (3) send_sample(SAMPLE_BITS'($urandom));

      while (random_sent < RANDOM_SAMPLES) begin
         settle();
         load_setting();
         swing = swing_type'($urandom_range(SWING_EDGES));
         held  = SAMPLE_BITS'($urandom);
         repeat ($urandom_range(90, 20)) begin
            steady = (random_sent >= 600 && random_sent < 900);
            send_sample(pick_sample(swing, held));
            random_sent++;
         end
      end
      steady = 1'b0;
      settle();

      if (fail_count == 0 && words_in_flight == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
